>>> sv/itmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed timer min-heap package
// Shared codes, command and status types for the timer heap block.
// ----------------------------------------------------------------------------
package itmh_pkg;

   localparam int HANDLE_W   = 6;
   localparam int DEADLINE_W = 48;
   localparam int SIZE_W     = 7;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_FIRE   = 2'd2;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   typedef enum logic [4:0] {
      OP_IDLE,
      OP_LOAD,
      OP_ADD,
      OP_CAN,
      OP_CAN_POS,
      OP_CAN_LAST,
      OP_FIRE,
      OP_FIRE_RT,
      OP_FIRE_LAST,
      OP_UP_RD,
      OP_UP_CMP,
      OP_DN_L,
      OP_DN_R,
      OP_DN_CMP,
      OP_DN_MV,
      OP_DN_END,
      OP_EMIT_RD,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] rtype;
      logic       add_ok;
      logic       found;
      logic       pos_last;
      logic       cnt_zero;
      logic       cnt_one;
      logic       root_due;
      logic       hole_zero;
      logic       up_less;
      logic       l_in;
      logic       best_sel;
      logic       moved;
      logic       out_free;
      logic       fire_more;
   } status_type;

endpackage
`default_nettype wire

>>> sv/itmh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] wa,
   input  wire logic [WIDTH-1:0]         wd,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] ra,
   output logic      [WIDTH-1:0]         rd
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   assign rd = rd_ff;

endmodule
`default_nettype wire

>>> sv/itmh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer heap controller
// Sequences add, cancel and fire requests through sift steps and result output.
// ----------------------------------------------------------------------------
module itmh_ctrl
   import itmh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type st,
   output cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_ADD, S_CAN, S_CAN_POS, S_CAN_LAST, S_FIRE, S_FIRE_RT,
      S_FIRE_LAST, S_UP_RD, S_UP_CMP, S_DN_L, S_DN_R, S_DN_CMP, S_DN_MV,
      S_DN_END, S_EMIT_RD, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_IDLE;
      case (state_ff)
         S_IDLE: begin
            cmd.op = OP_LOAD;
            if (req_valid) state_in = S_DISP;
         end
         S_DISP: begin
            case (st.rtype)
               REQ_ADD:    state_in = S_ADD;
               REQ_CANCEL: state_in = S_CAN;
               REQ_FIRE:   state_in = S_FIRE;
               default:    state_in = S_IDLE;
            endcase
         end
         S_ADD: begin
            cmd.op   = OP_ADD;
            state_in = st.add_ok ? S_UP_RD : S_EMIT_RD;
         end
         S_CAN: begin
            cmd.op   = OP_CAN;
            state_in = st.found ? S_CAN_POS : S_EMIT_RD;
         end
         S_CAN_POS: begin
            cmd.op   = OP_CAN_POS;
            state_in = st.pos_last ? S_EMIT_RD : S_CAN_LAST;
         end
         S_CAN_LAST: begin
            cmd.op   = OP_CAN_LAST;
            state_in = S_DN_L;
         end
         S_FIRE: begin
            cmd.op   = OP_FIRE;
            state_in = st.cnt_zero ? S_EMIT_RD : S_FIRE_RT;
         end
         S_FIRE_RT: begin
            cmd.op   = OP_FIRE_RT;
            state_in = (!st.root_due || st.cnt_one) ? S_EMIT_RD : S_FIRE_LAST;
         end
         S_FIRE_LAST: begin
            cmd.op   = OP_FIRE_LAST;
            state_in = S_DN_L;
         end
         S_UP_RD: begin
            cmd.op   = OP_UP_RD;
            state_in = st.hole_zero ? S_EMIT_RD : S_UP_CMP;
         end
         S_UP_CMP: begin
            cmd.op   = OP_UP_CMP;
            state_in = st.up_less ? S_UP_RD : S_EMIT_RD;
         end
         S_DN_L: begin
            cmd.op   = OP_DN_L;
            state_in = st.l_in ? S_DN_R : S_DN_END;
         end
         S_DN_R: begin
            cmd.op   = OP_DN_R;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            cmd.op   = OP_DN_CMP;
            state_in = S_DN_MV;
         end
         S_DN_MV: begin
            cmd.op   = OP_DN_MV;
            state_in = st.best_sel ? S_DN_L : S_DN_END;
         end
         S_DN_END: begin
            // An element that never moved down may still have to move up.
            cmd.op   = OP_DN_END;
            state_in = st.moved ? S_EMIT_RD : S_UP_RD;
         end
         S_EMIT_RD: begin
            cmd.op   = OP_EMIT_RD;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.op = OP_EMIT;
            if (st.out_free) state_in = st.fire_more ? S_FIRE : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule
`default_nettype wire

>>> sv/itmh_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer heap datapath
// Heap slot and position memories, the sifting element and the result register.
// ----------------------------------------------------------------------------
module itmh_dpath
   import itmh_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int NUM_HANDLES = 64,
   parameter int TIME_BITS   = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 st,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_type,
   input  wire logic [HANDLE_W-1:0]   req_handle,
   input  wire logic [DEADLINE_W-1:0] req_deadline,
   input  wire logic [DEADLINE_W-1:0] req_now_time,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [HANDLE_W-1:0]        rsp_out_handle,
   output logic                       rsp_accepted,
   output logic                       rsp_became_earliest,
   output logic [DEADLINE_W-1:0]      rsp_earliest_deadline,
   output logic                       rsp_nonempty,
   output logic [SIZE_W-1:0]          rsp_queue_size,
   output logic                       rsp_last
);

   localparam int SW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int HW = $clog2(NUM_HANDLES);
   localparam int EW = HANDLE_W + TIME_BITS;

   logic [1:0]            rtype_ff, rtype_in;
   logic [HANDLE_W-1:0]   rh_ff, rh_in;
   logic [TIME_BITS-1:0]  rdl_ff, rdl_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [PW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         hole_ff, hole_in;
   logic [HANDLE_W-1:0]   eh_ff, eh_in;
   logic [TIME_BITS-1:0]  ed_ff, ed_in;
   logic [HANDLE_W-1:0]   bh_ff, bh_in;
   logic [TIME_BITS-1:0]  bd_ff, bd_in;
   logic [SW-1:0]         bidx_ff, bidx_in;
   logic                  bsel_ff, bsel_in;
   logic                  rrd_ff, rrd_in;
   logic                  moved_ff, moved_in;
   logic [1:0]            kind_ff, kind_in;
   logic [HANDLE_W-1:0]   resh_ff, resh_in;
   logic                  acc_ff, acc_in;
   logic                  early_ff, early_in;
   logic                  valid_ff [NUM_HANDLES];
   logic                  valid_in [NUM_HANDLES];

   logic                  ov_ff, ov_in;
   logic [1:0]            okind_ff, okind_in;
   logic [HANDLE_W-1:0]   oh_ff, oh_in;
   logic                  oacc_ff, oacc_in;
   logic                  oearly_ff, oearly_in;
   logic [DEADLINE_W-1:0] odl_ff, odl_in;
   logic                  one_ff, one_in;
   logic [SIZE_W-1:0]     osz_ff, osz_in;
   logic                  olast_ff, olast_in;

   logic                  s_we, s_re;
   logic [SW-1:0]         s_wa, s_ra;
   logic [EW-1:0]         s_wd, s_rd;
   logic                  p_we, p_re;
   logic [HW-1:0]         p_wa, p_ra;
   logic [SW-1:0]         p_wd, p_rd;

   logic [HANDLE_W-1:0]   rd_h;
   logic [TIME_BITS-1:0]  rd_d;
   logic [HW-1:0]         hidx;
   logic                  h_ok;
   logic [SW+1:0]         l_w, r_w;
   logic                  r_in;
   logic [SW-1:0]         parent;
   logic [SW-1:0]         last_slot;

   itmh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slot_ram (
      .clock(clock), .we(s_we), .wa(s_wa), .wd(s_wd),
      .re(s_re), .ra(s_ra), .rd(s_rd)
   );

   itmh_ram #(.WIDTH(SW), .DEPTH(NUM_HANDLES)) u_pos_ram (
      .clock(clock), .we(p_we), .wa(p_wa), .wd(p_wd),
      .re(p_re), .ra(p_ra), .rd(p_rd)
   );

   assign rd_h      = s_rd[EW-1:TIME_BITS];
   assign rd_d      = s_rd[TIME_BITS-1:0];
   assign hidx      = HW'(rh_ff);
   assign h_ok      = (32'(rh_ff) < 32'(NUM_HANDLES));
   assign l_w       = {1'b0, hole_ff, 1'b1};
   assign r_w       = l_w + 1'b1;
   assign r_in      = (r_w < (SW+2)'(cnt_ff));
   assign parent    = (hole_ff - 1'b1) >> 1;
   assign last_slot = SW'(cnt_ff - 1'b1);

   always_comb begin
      st.rtype     = rtype_ff;
      st.add_ok    = h_ok && (cnt_ff < PW'(CAPACITY)) && !valid_ff[hidx];
      st.found     = h_ok && valid_ff[hidx];
      st.pos_last  = (p_rd == last_slot);
      st.cnt_zero  = (cnt_ff == '0);
      st.cnt_one   = (cnt_ff == PW'(1));
      st.root_due  = (rd_d <= now_ff);
      st.hole_zero = (hole_ff == '0);
      st.up_less   = (ed_ff < rd_d);
      st.l_in      = (l_w < (SW+2)'(cnt_ff));
      st.best_sel  = bsel_ff;
      st.moved     = moved_ff;
      st.out_free  = !ov_ff || rsp_ready;
      st.fire_more = (kind_ff == KIND_FIRED) && (cnt_ff != '0) && (rd_d <= now_ff);
   end

   always_comb begin
      rtype_in = rtype_ff;  rh_in = rh_ff;  rdl_in = rdl_ff;  now_in = now_ff;
      cnt_in = cnt_ff;  hole_in = hole_ff;  eh_in = eh_ff;  ed_in = ed_ff;
      bh_in = bh_ff;  bd_in = bd_ff;  bidx_in = bidx_ff;  bsel_in = bsel_ff;
      rrd_in = rrd_ff;  moved_in = moved_ff;  kind_in = kind_ff;
      resh_in = resh_ff;  acc_in = acc_ff;  early_in = early_ff;
      valid_in = valid_ff;
      ov_in = ov_ff;  okind_in = okind_ff;  oh_in = oh_ff;  oacc_in = oacc_ff;
      oearly_in = oearly_ff;  odl_in = odl_ff;  one_in = one_ff;
      osz_in = osz_ff;  olast_in = olast_ff;
      s_we = 1'b0;  s_wa = hole_ff;  s_wd = {eh_ff, ed_ff};
      s_re = 1'b0;  s_ra = '0;
      p_we = 1'b0;  p_wa = HW'(eh_ff);  p_wd = hole_ff;
      p_re = 1'b0;  p_ra = hidx;

      if (ov_ff && rsp_ready) ov_in = 1'b0;

      case (cmd.op)
         OP_LOAD: begin
            if (req_valid) begin
               rtype_in = req_type;
               rh_in    = req_handle;
               rdl_in   = TIME_BITS'(req_deadline);
               now_in   = TIME_BITS'(req_now_time);
            end
         end
         OP_ADD: begin
            kind_in  = KIND_ADD;
            resh_in  = rh_ff;
            acc_in   = st.add_ok;
            early_in = 1'b0;
            if (st.add_ok) begin
               eh_in          = rh_ff;
               ed_in          = rdl_ff;
               hole_in        = SW'(cnt_ff);
               cnt_in         = cnt_ff + 1'b1;
               valid_in[hidx] = 1'b1;
            end
         end
         OP_CAN: begin
            kind_in  = KIND_CANCEL;
            resh_in  = rh_ff;
            acc_in   = st.found;
            early_in = 1'b0;
            p_re     = st.found;
         end
         OP_CAN_POS: begin
            hole_in        = p_rd;
            cnt_in         = cnt_ff - 1'b1;
            valid_in[hidx] = 1'b0;
            if (!st.pos_last) begin
               s_re = 1'b1;
               s_ra = last_slot;
            end
         end
         OP_CAN_LAST, OP_FIRE_LAST: begin
            // The last entry refills the freed slot and sifts from there.
            eh_in    = rd_h;
            ed_in    = rd_d;
            moved_in = 1'b0;
            if (cmd.op == OP_FIRE_LAST) hole_in = '0;
         end
         OP_FIRE: begin
            acc_in   = 1'b0;
            early_in = 1'b0;
            if (st.cnt_zero) begin
               kind_in = KIND_NONE;
               resh_in = '0;
            end else begin
               s_re = 1'b1;
               s_ra = '0;
            end
         end
         OP_FIRE_RT: begin
            if (st.root_due) begin
               kind_in              = KIND_FIRED;
               resh_in              = rd_h;
               cnt_in               = cnt_ff - 1'b1;
               valid_in[HW'(rd_h)]  = 1'b0;
               if (!st.cnt_one) begin
                  s_re = 1'b1;
                  s_ra = last_slot;
               end
            end else begin
               kind_in = KIND_NONE;
               resh_in = '0;
            end
         end
         OP_UP_RD: begin
            if (st.hole_zero) begin
               s_we     = 1'b1;
               p_we     = 1'b1;
               early_in = (kind_ff == KIND_ADD);
            end else begin
               s_re = 1'b1;
               s_ra = parent;
            end
         end
         OP_UP_CMP: begin
            s_we = 1'b1;
            p_we = 1'b1;
            if (st.up_less) begin
               s_wd    = s_rd;
               p_wa    = HW'(rd_h);
               hole_in = parent;
            end
         end
         OP_DN_L: begin
            if (st.l_in) begin
               s_re = 1'b1;
               s_ra = SW'(l_w);
            end
         end
         OP_DN_R: begin
            if (rd_d < ed_ff) begin
               bh_in   = rd_h;
               bd_in   = rd_d;
               bidx_in = SW'(l_w);
               bsel_in = 1'b1;
            end else begin
               bsel_in = 1'b0;
            end
            rrd_in = r_in;
            if (r_in) begin
               s_re = 1'b1;
               s_ra = SW'(r_w);
            end
         end
         OP_DN_CMP: begin
            if (rrd_ff && (rd_d < (bsel_ff ? bd_ff : ed_ff))) begin
               bh_in   = rd_h;
               bd_in   = rd_d;
               bidx_in = SW'(r_w);
               bsel_in = 1'b1;
            end
         end
         OP_DN_MV: begin
            if (bsel_ff) begin
               s_we     = 1'b1;
               s_wd     = {bh_ff, bd_ff};
               p_we     = 1'b1;
               p_wa     = HW'(bh_ff);
               hole_in  = bidx_ff;
               moved_in = 1'b1;
            end
         end
         OP_DN_END: begin
            s_we = moved_ff;
            p_we = moved_ff;
         end
         OP_EMIT_RD: begin
            s_re = 1'b1;
            s_ra = '0;
         end
         OP_EMIT: begin
            if (st.out_free) begin
               ov_in     = 1'b1;
               okind_in  = kind_ff;
               oh_in     = resh_ff;
               oacc_in   = acc_ff;
               oearly_in = early_ff;
               odl_in    = (cnt_ff != '0) ? DEADLINE_W'(rd_d) : '1;
               one_in    = (cnt_ff != '0);
               osz_in    = SIZE_W'(cnt_ff);
               olast_in  = !st.fire_more;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      rtype_ff <= rtype_in;  rh_ff <= rh_in;  rdl_ff <= rdl_in;  now_ff <= now_in;
      hole_ff <= hole_in;  eh_ff <= eh_in;  ed_ff <= ed_in;
      bh_ff <= bh_in;  bd_ff <= bd_in;  bidx_ff <= bidx_in;  bsel_ff <= bsel_in;
      rrd_ff <= rrd_in;  moved_ff <= moved_in;  kind_ff <= kind_in;
      resh_ff <= resh_in;  acc_ff <= acc_in;  early_ff <= early_in;
      okind_ff <= okind_in;  oh_ff <= oh_in;  oacc_ff <= oacc_in;
      oearly_ff <= oearly_in;  odl_ff <= odl_in;  one_ff <= one_in;
      osz_ff <= osz_in;  olast_ff <= olast_in;
      if (reset) begin
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
         for (int i = 0; i < NUM_HANDLES; i++) valid_ff[i] <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         ov_ff    <= ov_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid             = ov_ff;
   assign rsp_kind              = okind_ff;
   assign rsp_out_handle        = oh_ff;
   assign rsp_accepted          = oacc_ff;
   assign rsp_became_earliest   = oearly_ff;
   assign rsp_earliest_deadline = odl_ff;
   assign rsp_nonempty          = one_ff;
   assign rsp_queue_size        = osz_ff;
   assign rsp_last              = olast_ff;

endmodule
`default_nettype wire

>>> sv/indexed_timer_min_heap_top.sv
// An add sifts up one level per read and compare of the parent; a cancel or
// fired item sifts down one level per read and compare of both children, each
// sift step waiting on the single read port of the heap slot memory.
// Items are handled one at a time; a fire request gives one item per expired entry,
// or one none item if no entry is due. Reset (synchronous, active high) empties the
// heap; slot memory contents are left as they are and never used before written.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed timer min-heap
// Binary min-heap of timer handles by deadline with a per-handle position map.
// ----------------------------------------------------------------------------
module indexed_timer_min_heap_top
   import itmh_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int NUM_HANDLES = 64,
   parameter int TIME_BITS   = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_type,
   input  wire logic [HANDLE_W-1:0]   req_handle,
   input  wire logic [DEADLINE_W-1:0] req_deadline,
   input  wire logic [DEADLINE_W-1:0] req_now_time,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [HANDLE_W-1:0]        rsp_out_handle,
   output logic                       rsp_accepted,
   output logic                       rsp_became_earliest,
   output logic [DEADLINE_W-1:0]      rsp_earliest_deadline,
   output logic                       rsp_nonempty,
   output logic [SIZE_W-1:0]          rsp_queue_size,
   output logic                       rsp_last
);

   cmd_type    cmd;
   status_type st;

   itmh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_ready(req_ready), .st(st), .cmd(cmd)
   );

   itmh_dpath #(
      .CAPACITY(CAPACITY), .NUM_HANDLES(NUM_HANDLES), .TIME_BITS(TIME_BITS)
   ) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .req_valid(req_valid), .req_type(req_type), .req_handle(req_handle),
      .req_deadline(req_deadline), .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_out_handle(rsp_out_handle), .rsp_accepted(rsp_accepted),
      .rsp_became_earliest(rsp_became_earliest),
      .rsp_earliest_deadline(rsp_earliest_deadline),
      .rsp_nonempty(rsp_nonempty), .rsp_queue_size(rsp_queue_size),
      .rsp_last(rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_queue_size) <= 32'(CAPACITY)))
      else $error("queue size beyond capacity");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_nonempty == (rsp_queue_size != '0)))
      else $error("nonempty flag disagrees with size");

   a_empty_deadline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_nonempty) |-> (rsp_earliest_deadline == '1))
      else $error("empty heap must report all-ones deadline");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_FIRED)) |-> rsp_last)
      else $error("only fired items may be followed by more");
`endif

endmodule
`default_nettype wire

>>> sim/indexed_timer_min_heap_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed timer min-heap testbench
// Drives add, cancel, fire and reserved requests against a behavioral heap predictor
// and compares every result item field by field, with random stalls.
// ----------------------------------------------------------------------------
module indexed_timer_min_heap_top_tb
   import itmh_pkg::*;
();

   localparam int CAP = 64;
   localparam logic [47:0] NO_DEADLINE = 48'hFFFF_FFFF_FFFF;
   localparam int STALL_LIMIT = 20000;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  hnd;
      logic        accepted;
      logic        early;
      logic [47:0] root_dl;
      logic        nonempty;
      logic [6:0]  size;
      logic        last;
   } timer_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_type = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic [DEADLINE_W-1:0] req_deadline = '0;
   logic [DEADLINE_W-1:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_kind;
   logic [HANDLE_W-1:0] rsp_out_handle;
   logic rsp_accepted, rsp_became_earliest, rsp_nonempty, rsp_last;
   logic [DEADLINE_W-1:0] rsp_earliest_deadline;
   logic [SIZE_W-1:0] rsp_queue_size;

   indexed_timer_min_heap_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor state.
   logic [5:0]  heap_hnd [CAP];
   logic [47:0] heap_dl [CAP];
   int          hnd_pos [64];
   int          heap_count;
   timer_result_type pending_results[$];

   int  errors = 0;
   bit  sender_gaps = 1;
   bit  receiver_gaps = 1;
   int  hold_off = 0;
   int  idle_cycles = 0;

   function automatic void swap_entries(int a, int b);
      logic [5:0] h;
      logic [47:0] d;
      h = heap_hnd[a]; d = heap_dl[a];
      heap_hnd[a] = heap_hnd[b]; heap_dl[a] = heap_dl[b];
      heap_hnd[b] = h; heap_dl[b] = d;
      hnd_pos[heap_hnd[a]] = a;
      hnd_pos[heap_hnd[b]] = b;
   endfunction

   function automatic void bubble_up(int i);
      int p;
      while (i != 0) begin
         p = (i - 1) / 2;
         if (!(heap_dl[i] < heap_dl[p])) break;
         swap_entries(i, p);
         i = p;
      end
   endfunction

   function automatic void bubble_down(int i);
      int l, r, s;
      forever begin
         l = 2 * i + 1;
         r = l + 1;
         s = i;
         if (l < heap_count && heap_dl[l] < heap_dl[s]) s = l;
         if (r < heap_count && heap_dl[r] < heap_dl[s]) s = r;
         if (s == i) break;
         swap_entries(i, s);
         i = s;
      end
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [5:0] h,
                                       logic acc, logic early, logic last);
      timer_result_type r;
      r.kind = kind; r.hnd = h; r.accepted = acc; r.early = early;
      r.root_dl = heap_count != 0 ? heap_dl[0] : NO_DEADLINE;
      r.nonempty = heap_count != 0;
      r.size = heap_count[6:0];
      r.last = last;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void predict_timer_op(logic [1:0] rt, logic [5:0] h,
                                            logic [47:0] dl, logic [47:0] now);
      int i, tail, n;
      logic ok;
      logic early;
      logic [5:0] fh;
      case (rt)
         REQ_ADD: begin
            ok = heap_count < CAP && hnd_pos[h] >= CAP;
            early = 0;
            if (ok) begin
               heap_hnd[heap_count] = h;
               heap_dl[heap_count] = dl;
               hnd_pos[h] = heap_count;
               heap_count++;
               bubble_up(heap_count - 1);
               early = heap_hnd[0] == h;
            end
            push_result(KIND_ADD, h, ok, early, 1);
         end
         REQ_CANCEL: begin
            ok = hnd_pos[h] < heap_count;
            if (ok) begin
               i = hnd_pos[h];
               tail = heap_count - 1;
               if (i != tail) swap_entries(i, tail);
               heap_count--;
               hnd_pos[h] = CAP;
               if (i != tail) begin
                  bubble_down(i);
                  bubble_up(i);
               end
            end
            push_result(KIND_CANCEL, h, ok, 0, 1);
         end
         REQ_FIRE: begin
            n = 0;
            while (heap_count > 0 && heap_dl[0] <= now) begin
               fh = heap_hnd[0];
               tail = heap_count - 1;
               if (tail != 0) swap_entries(0, tail);
               heap_count--;
               hnd_pos[fh] = CAP;
               if (tail != 0) bubble_down(0);
               push_result(KIND_FIRED, fh, 0, 0, 0);
               n++;
            end
            if (n == 0) push_result(KIND_NONE, 0, 0, 0, 1);
            else pending_results[$].last = 1;
         end
         default: ;
      endcase
   endfunction

   // Valid stays high from one item to the next unless an idle gap comes in
   // between, so it is assigned at most once in any time step.
   task automatic send_request(logic [1:0] rt, logic [5:0] h,
                               logic [47:0] dl, logic [47:0] now);
      int gap;
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= rt;
      req_handle <= h;
      req_deadline <= dl;
      req_now_time <= now;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_timer_op(rt, h, dl, now);
   endtask

   // Receiver stall pattern.
   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_ready <= 0;
            hold_off--;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 13);
            rsp_ready <= 0;
            repeat (burst - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // Result checker.
   initial begin
      timer_result_type exp_r;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result item, kind %0d", rsp_kind);
               errors++;
            end else begin
               exp_r = pending_results.pop_front();
               if (rsp_kind !== exp_r.kind) begin
                  $error("kind exp %0d got %0d", exp_r.kind, rsp_kind); errors++;
               end
               if (rsp_out_handle !== exp_r.hnd) begin
                  $error("out_handle exp %0d got %0d", exp_r.hnd, rsp_out_handle);
                  errors++;
               end
               if (rsp_accepted !== exp_r.accepted) begin
                  $error("accepted exp %0d got %0d", exp_r.accepted, rsp_accepted);
                  errors++;
               end
               if (rsp_became_earliest !== exp_r.early) begin
                  $error("became_earliest exp %0d got %0d", exp_r.early,
                         rsp_became_earliest);
                  errors++;
               end
               if (rsp_earliest_deadline !== exp_r.root_dl) begin
                  $error("earliest_deadline exp %h got %h", exp_r.root_dl,
                         rsp_earliest_deadline);
                  errors++;
               end
               if (rsp_nonempty !== exp_r.nonempty) begin
                  $error("nonempty exp %0d got %0d", exp_r.nonempty, rsp_nonempty);
                  errors++;
               end
               if (rsp_queue_size !== exp_r.size) begin
                  $error("queue_size exp %0d got %0d", exp_r.size, rsp_queue_size);
                  errors++;
               end
               if (rsp_last !== exp_r.last) begin
                  $error("last exp %0d got %0d", exp_r.last, rsp_last);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic logic [47:0] rand_deadline();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic test_directed();
      send_request(REQ_FIRE, 0, 0, NO_DEADLINE);
      send_request(REQ_CANCEL, 5, 0, 0);
      send_request(REQ_ADD, 63, NO_DEADLINE, 0);
      send_request(REQ_ADD, 0, 0, 0);
      send_request(REQ_ADD, 0, 48'h1234, 0);
      send_request(REQ_ADD, 21, 48'h5555_5555_5555, 0);
      send_request(REQ_ADD, 42, 48'hAAAA_AAAA_AAAA, 0);
      send_request(REQ_ADD, 7, 0, 0);
      send_request(REQ_RESERVED, 9, 48'h1, 48'h1);
      send_request(REQ_CANCEL, 63, 0, 0);
      send_request(REQ_CANCEL, 63, 0, 0);
      send_request(REQ_FIRE, 0, 0, 0);
      send_request(REQ_FIRE, 0, 0, 48'h5555_5555_5554);
      send_request(REQ_FIRE, 0, 0, NO_DEADLINE);
   endtask

   // Fill the heap to capacity so that a further add is rejected.
   task automatic test_full_heap();
      for (int i = 0; i < 64; i++)
         send_request(REQ_ADD, i[5:0], {32'd0, 16'($urandom)}, 0);
      send_request(REQ_ADD, 3, 0, 0);
      send_request(REQ_FIRE, 0, 0, NO_DEADLINE);
   endtask

   // The receiver stops for a long stretch while fires keep coming.
   task automatic test_backpressure();
      for (int i = 0; i < 8; i++)
         send_request(REQ_ADD, i[5:0], 48'(i), 0);
      hold_off = 300;
      for (int i = 0; i < 10; i++)
         send_request(REQ_FIRE, 0, 0, 48'(i));
   endtask

   task automatic test_random(int count, bit quiet);
      int sel;
      logic [47:0] base;
      if (quiet) begin
         sender_gaps = 0;
         receiver_gaps = 0;
      end
      base = 48'($urandom_range(0, 1000));
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50)
            send_request(REQ_ADD, 6'($urandom),
                         ($urandom_range(0, 9) == 0) ? rand_deadline()
                            : base + 48'($urandom_range(0, 2000)), 0);
         else if (sel < 75)
            send_request(REQ_CANCEL, 6'($urandom), rand_deadline(), 0);
         else if (sel < 97) begin
            base += 48'($urandom_range(0, 300));
            send_request(REQ_FIRE, 6'($urandom), rand_deadline(), base);
         end else
            send_request(REQ_RESERVED, 6'($urandom), rand_deadline(), rand_deadline());
      end
   endtask

   initial begin
      heap_count = 0;
      for (int i = 0; i < 64; i++) hnd_pos[i] = CAP;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_full_heap();
      test_backpressure();
      test_random(110, 0);
      test_random(40, 1);
      req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
sv/itmh_pkg.sv
sv/itmh_ram.sv
sv/itmh_ctrl.sv
sv/itmh_dpath.sv
sv/indexed_timer_min_heap_top.sv
sim/indexed_timer_min_heap_top_tb.sv
